// ----- hw/rtl/aar_pkg.sv -----
// Shared constants and tables for the axis-angle rotation core.
`default_nettype none
package aar_pkg;
  localparam int COORD_WIDTH_DEF    = 32;
  localparam int AXIS_FRAC_BITS_DEF = 14;
  localparam int ANGLE_WIDTH_DEF    = 16;
  localparam int CORDIC_STAGES_DEF  = 16;
  localparam int AXIS_BITS          = 16;
  localparam int MAX_STAGES         = 24;
  localparam int CW                 = 34;   // CORDIC datapath width
  localparam int EW                 = 36;   // matrix entry width, Q6.30
  localparam logic signed [CW-1:0] CORDIC_GAIN  = 34'sd652032874;
  localparam logic signed [CW-1:0] QUARTER_TURN = 34'sd1073741824;
  localparam logic signed [EW-1:0] ENTRY_MAX = 36'sh7_FFFF_FFFF;
  localparam logic signed [EW-1:0] ENTRY_MIN = 36'sh8_0000_0000;

  function automatic logic signed [CW-1:0] atan_turn(input int i);
    logic signed [CW-1:0] r;
    case (i)
      0: r = 34'sd536870912;   1: r = 34'sd316933406;  2: r = 34'sd167458907;
      3: r = 34'sd85004756;    4: r = 34'sd42667331;   5: r = 34'sd21354465;
      6: r = 34'sd10679838;    7: r = 34'sd5340245;    8: r = 34'sd2670163;
      9: r = 34'sd1335086;     10: r = 34'sd667544;    11: r = 34'sd333772;
      12: r = 34'sd166886;     13: r = 34'sd83443;     14: r = 34'sd41721;
      15: r = 34'sd20860;      16: r = 34'sd10430;     17: r = 34'sd5215;
      18: r = 34'sd2607;       19: r = 34'sd1303;      20: r = 34'sd651;
      21: r = 34'sd325;        22: r = 34'sd162;       default: r = 34'sd81;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/aar_if.sv -----
// Valid/ready stream interfaces for points in and rotated points out.
`default_nettype none
interface aar_in_if #(parameter int COORD_WIDTH = 32, parameter int ANGLE_WIDTH = 16);
  logic valid;
  logic ready;
  logic signed [COORD_WIDTH-1:0] point_x, point_y, point_z;
  logic signed [15:0] axis_x, axis_y, axis_z;
  logic [ANGLE_WIDTH-1:0] turn_angle;
  modport source (output valid, point_x, point_y, point_z, axis_x, axis_y, axis_z,
                  turn_angle, input ready);
  modport sink (input valid, point_x, point_y, point_z, axis_x, axis_y, axis_z,
                turn_angle, output ready);
endinterface

interface aar_out_if #(parameter int COORD_WIDTH = 32);
  logic valid;
  logic ready;
  logic signed [COORD_WIDTH-1:0] rotated_x, rotated_y, rotated_z;
  modport source (output valid, rotated_x, rotated_y, rotated_z, input ready);
  modport sink (input valid, rotated_x, rotated_y, rotated_z, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/aar_cordic.sv -----
// Pipelined CORDIC: one rotation stage per register stage, sine/cosine in Q.30.
`default_nettype none
module aar_cordic
  import aar_pkg::*;
#(
  parameter int ANGLE_WIDTH   = ANGLE_WIDTH_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
  parameter int TW            = 8
) (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic [ANGLE_WIDTH-1:0]  angle,
  input  wire logic [TW-1:0]           tag_in,
  output logic signed [CW-1:0]         cos_q30,
  output logic signed [CW-1:0]         sin_q30,
  output logic [TW-1:0]                tag_out
);
  localparam int N = (CORDIC_STAGES < MAX_STAGES) ? CORDIC_STAGES : MAX_STAGES;
  logic signed [CW-1:0] x [N+1];
  logic signed [CW-1:0] y [N+1];
  logic signed [CW-1:0] z [N+1];
  logic                 up [N+1];
  logic [TW-1:0]        tg [N+1];
  logic signed [CW-1:0] z0;

  always_comb begin
    z0 = CW'($signed({1'b0, angle}) <<< (31 - ANGLE_WIDTH));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x[0]  <= CORDIC_GAIN;
      y[0]  <= '0;
      up[0] <= (z0 >= QUARTER_TURN);
      z[0]  <= (z0 >= QUARTER_TURN) ? z0 - QUARTER_TURN : z0;
      tg[0] <= tag_in;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z[i][CW-1]) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - atan_turn(i);
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + atan_turn(i);
        end
        up[i+1] <= up[i];
        tg[i+1] <= tg[i];
      end
    end
  end

  assign cos_q30 = up[N] ? -y[N] : x[N];
  assign sin_q30 = up[N] ? x[N] : y[N];
  assign tag_out = tg[N];
endmodule
`default_nettype wire

// ----- hw/rtl/aar_matrix.sv -----
// Rotation matrix build: quaternion products, entries saturated to Q6.30.
`default_nettype none
module aar_matrix
  import aar_pkg::*;
#(
  parameter int AXIS_FRAC_BITS = AXIS_FRAC_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic signed [CW-1:0]     cs,
  input  wire logic signed [CW-1:0]     sn,
  input  wire logic signed [AXIS_BITS-1:0] ax [3],
  output logic signed [EW-1:0]          m [9]
);
  localparam int F = AXIS_FRAC_BITS;
  // stage 1: trig squares, axis squares/products
  logic signed [CW-1:0] aa, ss, as1;
  logic signed [32:0]   sq [3];
  logic signed [32:0]   pr [3];  // xy, xz, yz
  logic signed [AXIS_BITS-1:0] ax1 [3];
  // stage 2: scaled terms
  logic signed [CW-1:0] aa2;
  logic signed [EW+2:0] dg2 [3];
  logic signed [EW+2:0] t2 [3];
  logic signed [EW+2:0] c2 [3];  // as*ax, as*ay, as*az

  function automatic logic signed [CW-1:0] rq30(input logic signed [2*CW-1:0] v);
    logic signed [2*CW-1:0] r;
    r = (v + (2*CW)'(64'sd1 <<< 29)) >>> 30;
    return r[CW-1:0];
  endfunction

  function automatic logic signed [EW+2:0] rshf(input logic signed [95:0] v, input int s);
    logic signed [95:0] r;
    r = (v + (96'sd1 <<< (s - 1))) >>> s;
    return r[EW+2:0];
  endfunction

  function automatic logic signed [EW-1:0] sat(input logic signed [EW+3:0] v);
    if (v > 40'(ENTRY_MAX)) return ENTRY_MAX;
    if (v < 40'(ENTRY_MIN)) return ENTRY_MIN;
    return v[EW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      aa  <= rq30((2*CW)'(cs) * (2*CW)'(cs));
      ss  <= rq30((2*CW)'(sn) * (2*CW)'(sn));
      as1 <= rq30((2*CW)'(cs) * (2*CW)'(sn));
      for (int k = 0; k < 3; k++) begin
        sq[k]  <= 33'(ax[k]) * 33'(ax[k]);
        ax1[k] <= ax[k];
      end
      pr[0] <= 33'(ax[0]) * 33'(ax[1]);
      pr[1] <= 33'(ax[0]) * 33'(ax[2]);
      pr[2] <= 33'(ax[1]) * 33'(ax[2]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      aa2    <= aa;
      dg2[0] <= rshf(96'(ss) * 96'(35'(sq[0]) - 35'(sq[1]) - 35'(sq[2])), 2*F);
      dg2[1] <= rshf(96'(ss) * 96'(35'(sq[1]) - 35'(sq[0]) - 35'(sq[2])), 2*F);
      dg2[2] <= rshf(96'(ss) * 96'(35'(sq[2]) - 35'(sq[0]) - 35'(sq[1])), 2*F);
      for (int k = 0; k < 3; k++) begin
        t2[k] <= rshf(96'(ss) * 96'(pr[k]), 2*F);
        c2[k] <= rshf(96'(as1) * 96'(ax1[k]), F);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m[0] <= sat(40'(aa2) + 40'(dg2[0]));
      m[4] <= sat(40'(aa2) + 40'(dg2[1]));
      m[8] <= sat(40'(aa2) + 40'(dg2[2]));
      m[1] <= sat((40'(t2[0]) - 40'(c2[2])) <<< 1);
      m[3] <= sat((40'(t2[0]) + 40'(c2[2])) <<< 1);
      m[2] <= sat((40'(t2[1]) + 40'(c2[1])) <<< 1);
      m[6] <= sat((40'(t2[1]) - 40'(c2[1])) <<< 1);
      m[5] <= sat((40'(t2[2]) - 40'(c2[0])) <<< 1);
      m[7] <= sat((40'(t2[2]) + 40'(c2[0])) <<< 1);
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/aar_apply.sv -----
// Matrix times point: products, row sums, rounding and saturation.
`default_nettype none
module aar_apply
  import aar_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic signed [EW-1:0]          m [9],
  input  wire logic signed [COORD_WIDTH-1:0] p [3],
  output logic signed [COORD_WIDTH-1:0]      r [3]
);
  localparam int PW = EW + COORD_WIDTH;
  localparam int SW = PW + 2;
  logic signed [PW-1:0] prod [9];
  logic signed [SW-1:0] sum [3];

  function automatic logic signed [COORD_WIDTH-1:0] fin(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] u;
    logic signed [SW-1:0] lim;
    u   = (v + (SW'(1) <<< 29)) >>> 30;
    lim = (SW'(1) <<< (COORD_WIDTH - 1)) - SW'(1);
    if (u > lim) return lim[COORD_WIDTH-1:0];
    if (u < -lim - SW'(1)) return COORD_WIDTH'(-lim - SW'(1));
    return u[COORD_WIDTH-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) prod[k] <= PW'(m[k]) * PW'(p[k % 3]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++)
        sum[k] <= SW'(prod[3*k]) + SW'(prod[3*k+1]) + SW'(prod[3*k+2]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) r[k] <= fin(sum[k]);
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/axis_angle_rotation_core.sv -----
// Top level of the axis-angle rotation core.
// channel | dir | payload
// pin     | in  | point_x/y/z, axis_x/y/z, turn_angle
// pout    | out | rotated_x/y/z
// One point per cycle while pout does not stall; the path runs through the CORDIC, then
// the matrix build, then the matrix-point product.
// The whole pipeline advances together; when pout stalls with a valid result, it freezes.
// Reset clears only the valid bits of the pipeline.
`default_nettype none
module axis_angle_rotation_core
  import aar_pkg::*;
#(
  parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
  parameter int AXIS_FRAC_BITS = AXIS_FRAC_BITS_DEF,
  parameter int ANGLE_WIDTH    = ANGLE_WIDTH_DEF,
  parameter int CORDIC_STAGES  = CORDIC_STAGES_DEF
) (
  input wire logic clk,
  input wire logic rst,
  aar_in_if.sink   pin,
  aar_out_if.source pout
);
  localparam int N   = (CORDIC_STAGES < MAX_STAGES) ? CORDIC_STAGES : MAX_STAGES;
  localparam int LAT = N + 1 + 6;
  localparam int TW  = 3*COORD_WIDTH + 3*AXIS_BITS;
  localparam int PL  = 3*COORD_WIDTH;

  logic en;
  logic [LAT-1:0] vld;
  logic [TW-1:0] tag_in, tag_c;
  logic signed [CW-1:0] cs, sn;
  logic signed [AXIS_BITS-1:0] ax [3];
  logic signed [EW-1:0] m [9];
  logic [PL-1:0] pd [3];
  logic signed [COORD_WIDTH-1:0] p [3];
  logic signed [COORD_WIDTH-1:0] r [3];

  assign en = !vld[LAT-1] || pout.ready;
  assign pin.ready = en;
  assign tag_in = {pin.point_x, pin.point_y, pin.point_z, pin.axis_x, pin.axis_y, pin.axis_z};

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[LAT-2:0], pin.valid};
  end

  aar_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STAGES(CORDIC_STAGES), .TW(TW)) u_cordic (
    .clk, .en, .angle(pin.turn_angle), .tag_in, .cos_q30(cs), .sin_q30(sn), .tag_out(tag_c)
  );

  assign ax[0] = tag_c[3*AXIS_BITS-1:2*AXIS_BITS];
  assign ax[1] = tag_c[2*AXIS_BITS-1:AXIS_BITS];
  assign ax[2] = tag_c[AXIS_BITS-1:0];

  aar_matrix #(.AXIS_FRAC_BITS(AXIS_FRAC_BITS)) u_matrix (
    .clk, .en, .cs, .sn, .ax, .m
  );

  // point delayed to line up with the matrix entries
  always_ff @(posedge clk) begin
    if (en) begin
      pd[0] <= tag_c[TW-1:3*AXIS_BITS];
      for (int k = 1; k < 3; k++) pd[k] <= pd[k-1];
    end
  end
  assign p[0] = pd[2][3*COORD_WIDTH-1:2*COORD_WIDTH];
  assign p[1] = pd[2][2*COORD_WIDTH-1:COORD_WIDTH];
  assign p[2] = pd[2][COORD_WIDTH-1:0];

  aar_apply #(.COORD_WIDTH(COORD_WIDTH)) u_apply (.clk, .en, .m, .p, .r);

  assign pout.valid = vld[LAT-1];
  assign pout.rotated_x = r[0];
  assign pout.rotated_y = r[1];
  assign pout.rotated_z = r[2];

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    pout.valid && !pout.ready |=> pout.valid && $stable(pout.rotated_x))
    else $error("result changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !pout.valid |-> pin.ready) else $error("ready low with empty output");
  a_reset: assert property (@(posedge clk) rst |=> !pout.valid)
    else $error("valid after reset");
endmodule
`default_nettype wire

// ----- tb/axis_angle_rotation_core_tb.sv -----
// Testbench for the axis-angle rotation core: random and directed points checked in order.
`timescale 1ns / 1ps
module axis_angle_rotation_core_tb;
  import aar_pkg::*;

  localparam int CWID = 32;
  localparam int FB = 14;
  localparam int AWID = 16;
  localparam int STAGES = 16;
  localparam int LATENCY = STAGES + 7;

  typedef struct packed {
    logic signed [CWID-1:0] x, y, z;
  } coord_t;

  typedef struct {
    logic signed [CWID-1:0] px, py, pz;
    logic signed [15:0] ax, ay, az;
    logic [AWID-1:0] ang;
  } point_req_t;

  class rotation_scoreboard;
    coord_t pending[$];
    int errors;
    int checked;

    // arithmetic shift, floor
    static function longint asr(longint v, int s);
      return v >>> s;
    endfunction

    static function longint rnd(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    static function longint sat(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // exact 3-term dot product kept in a wide vector, then rounded and saturated
    static function logic signed [CWID-1:0] dot_row(longint m0, longint m1, longint m2,
                                                  longint p0, longint p1, longint p2);
      logic signed [127:0] acc;
      logic signed [127:0] r;
      longint lim;
      acc = 128'(signed'(m0)) * 128'(signed'(p0)) + 128'(signed'(m1)) * 128'(signed'(p1))
            + 128'(signed'(m2)) * 128'(signed'(p2));
      r = (acc + (128'sd1 <<< 29)) >>> 30;
      lim = (longint'(1) <<< (CWID - 1)) - 1;
      if (r > 128'(signed'(lim))) r = 128'(signed'(lim));
      if (r < 128'(signed'(-lim - 1))) r = 128'(signed'(-lim - 1));
      return r[CWID-1:0];
    endfunction

    function coord_t rotate_point(point_req_t q);
      longint cx, cy, cz, dx, dy, cs, sn, aa, ss, sc, t, xx, yy, zz;
      longint a0, a1, a2;
      longint m[9];
      longint emax, emin;
      bit upper;
      coord_t res;
      emax = (longint'(1) <<< 35) - 1;
      emin = -(longint'(1) <<< 35);
      a0 = q.ax; a1 = q.ay; a2 = q.az;
      cx = CORDIC_GAIN; cy = 0;
      cz = longint'(q.ang) <<< (31 - AWID);
      upper = cz >= QUARTER_TURN;
      if (upper) cz -= QUARTER_TURN;
      for (int i = 0; i < STAGES && i < MAX_STAGES; i++) begin
        dx = asr(cy, i);
        dy = asr(cx, i);
        if (cz >= 0) begin
          cx -= dx; cy += dy; cz -= atan_turn(i);
        end else begin
          cx += dx; cy -= dy; cz += atan_turn(i);
        end
      end
      if (upper) begin
        cs = -cy; sn = cx;
      end else begin
        cs = cx; sn = cy;
      end
      aa = rnd(cs * cs, 30);
      ss = rnd(sn * sn, 30);
      sc = rnd(cs * sn, 30);
      xx = a0 * a0; yy = a1 * a1; zz = a2 * a2;
      m[0] = aa + rnd(ss * (xx - yy - zz), 2 * FB);
      m[4] = aa + rnd(ss * (yy - xx - zz), 2 * FB);
      m[8] = aa + rnd(ss * (zz - xx - yy), 2 * FB);
      t = rnd(ss * a0 * a1, 2 * FB);
      m[1] = 2 * (t - rnd(sc * a2, FB));
      m[3] = 2 * (t + rnd(sc * a2, FB));
      t = rnd(ss * a0 * a2, 2 * FB);
      m[2] = 2 * (t + rnd(sc * a1, FB));
      m[6] = 2 * (t - rnd(sc * a1, FB));
      t = rnd(ss * a1 * a2, 2 * FB);
      m[5] = 2 * (t - rnd(sc * a0, FB));
      m[7] = 2 * (t + rnd(sc * a0, FB));
      for (int k = 0; k < 9; k++) m[k] = sat(m[k], emin, emax);
      res.x = dot_row(m[0], m[1], m[2], q.px, q.py, q.pz);
      res.y = dot_row(m[3], m[4], m[5], q.px, q.py, q.pz);
      res.z = dot_row(m[6], m[7], m[8], q.px, q.py, q.pz);
      return res;
    endfunction

    function void note_point(point_req_t q);
      pending.push_back(rotate_point(q));
    endfunction

    function void check_result(coord_t got);
      coord_t exp_c;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result expected none actual %h %h %h", $time,
                 got.x, got.y, got.z);
        errors++;
        return;
      end
      exp_c = pending.pop_front();
      if (got.x !== exp_c.x) begin
        $display("%0t: rotated_x expected %h actual %h", $time, exp_c.x, got.x);
        errors++;
      end
      if (got.y !== exp_c.y) begin
        $display("%0t: rotated_y expected %h actual %h", $time, exp_c.y, got.y);
        errors++;
      end
      if (got.z !== exp_c.z) begin
        $display("%0t: rotated_z expected %h actual %h", $time, exp_c.z, got.z);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  aar_in_if #(.COORD_WIDTH(CWID), .ANGLE_WIDTH(AWID)) pin ();
  aar_out_if #(.COORD_WIDTH(CWID)) pout ();

  axis_angle_rotation_core #(
    .COORD_WIDTH(CWID), .AXIS_FRAC_BITS(FB), .ANGLE_WIDTH(AWID), .CORDIC_STAGES(STAGES)
  ) i_dut (
    .clk(clk), .rst(rst), .pin(pin), .pout(pout)
  );

  rotation_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_off;
  int sent;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // receiver: random ready, plus a long hold-off when requested
  always @(posedge clk) begin
    if (rst) begin
      pout.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      pout.ready <= 1'b0;
    end else begin
      pout.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && pout.valid && pout.ready) begin
      sb.check_result('{pout.rotated_x, pout.rotated_y, pout.rotated_z});
    end
  end

  task automatic send_point(point_req_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      pin.valid <= 1'b0;
      @(posedge clk);
    end
    pin.valid <= 1'b1;
    pin.point_x <= q.px;
    pin.point_y <= q.py;
    pin.point_z <= q.pz;
    pin.axis_x <= q.ax;
    pin.axis_y <= q.ay;
    pin.axis_z <= q.az;
    pin.turn_angle <= q.ang;
    @(posedge clk);
    while (!pin.ready) @(posedge clk);
    sb.note_point(q);
    sent++;
  endtask

  task automatic release_input();
    pin.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [15:0] unit_axis_comp();
    case ($urandom_range(3))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'sd0;
      default: return 16'($signed($urandom_range(32768)) - 16384);
    endcase
  endfunction

  function automatic logic signed [CWID-1:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return $urandom;
      default: return 32'($signed($urandom_range(2000000)) - 1000000) <<< 4;
    endcase
  endfunction

  function automatic point_req_t random_point();
    point_req_t q;
    q.px = rand_coord();
    q.py = rand_coord();
    q.pz = rand_coord();
    if ($urandom_range(9) == 0) begin
      // axis far from unit length, any bit pattern
      q.ax = 16'($urandom); q.ay = 16'($urandom); q.az = 16'($urandom);
    end else begin
      q.ax = unit_axis_comp(); q.ay = unit_axis_comp(); q.az = unit_axis_comp();
    end
    q.ang = AWID'($urandom);
    return q;
  endfunction

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  initial begin
    point_req_t q;
    logic [AWID-1:0] angs[8];
    sb = new();
    sent = 0;
    hold_off = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst = 1'b1;
    pin.valid = 1'b0;
    pin.point_x = '0; pin.point_y = '0; pin.point_z = '0;
    pin.axis_x = '0; pin.axis_y = '0; pin.axis_z = '0;
    pin.turn_angle = '0;
    pout.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: angle extremes and quadrant boundaries, unit axes, zero axis, saturation
    angs = '{16'h0000, 16'h4000, 16'h7FFF, 16'h8000, 16'hBFFF, 16'hC000, 16'hFFFF, 16'h2000};
    foreach (angs[i]) begin
      q = '{32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000,
            16'sd0, 16'sd0, 16'sd16384, angs[i]};
      send_point(q);
    end
    q = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'sd16384, 16'sd0, 16'sd0, 16'h6000};
    send_point(q);
    q = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 16'sd0, -16'sd16384, 16'sd0, 16'h1234};
    send_point(q);
    q = '{32'sh1234_5678, -32'sh0765_4321, 32'sh0000_0001, 16'sd0, 16'sd0, 16'sd0, 16'h3000};
    send_point(q);
    q = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
          16'h9000};
    send_point(q);
    q = '{32'sh4000_0000, 32'sh4000_0000, 32'sh4000_0000, 16'sh8000, 16'sh8000, 16'sh8000,
          16'hFFFF};
    send_point(q);
    q = '{32'shFFFF_FFFF, 32'sh0, 32'sh1, 16'shFFFF, 16'sh5555, 16'shAAAA, 16'h5555};
    send_point(q);
    release_input();
    drain();

    // random phases with different idle mixes
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 14 : (ph == 1) ? 69 : 0;
      recv_idle_pct = (ph == 0) ? 69 : (ph == 1) ? 14 : 0;
      for (int n = 0; n < 445; n++) begin
        if (ph == 2 && n == 100) hold_off <= 200;
        send_point(random_point());
      end
      release_input();
      // sender pauses until the pipeline has emptied
      drain();
    end

    $display("Rotated %0d points (%0d checked): angle/axis extremes, bad axes, saturation,",
             sent, sb.checked);
    $display("three idle mixes and a long output stall.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
hw/rtl/aar_pkg.sv
hw/rtl/aar_if.sv
hw/rtl/aar_cordic.sv
hw/rtl/aar_matrix.sv
hw/rtl/aar_apply.sv
hw/rtl/axis_angle_rotation_core.sv
tb/axis_angle_rotation_core_tb.sv
